[rtl/pafnf_pkg.sv]
package pafnf_pkg;

  localparam int MaxParts = 32;
  localparam int IdxBits = $clog2(MaxParts);
  localparam int CntBits = $clog2(MaxParts + 1);
  localparam int AddrBits = 16;
  localparam logic [AddrBits-1:0] MemReset = AddrBits'(512);

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NOSPACE  = 3'd1,
    ST_EXISTS   = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_FULL     = 3'd4,
    ST_BAD      = 3'd5
  } status_t;

  typedef enum logic {
    FUNC_ALLOC = 1'b0,
    FUNC_FREE  = 1'b1
  } func_t;

  typedef enum logic {
    REG_FIT_POLICY = 1'b0,
    REG_MEM_UNITS  = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [AddrBits-1:0] start;
    logic [AddrBits-1:0] size;
    logic [15:0]         owner;
    logic                used;
  } entry_t;

  typedef struct packed {
    logic               we;
    logic [IdxBits-1:0] waddr;
    entry_t             wdata;
    logic [IdxBits-1:0] raddr;
  } mem_req_t;

endpackage

[rtl/pafnf_table.sv]
module pafnf_table (
  input  logic              clk,
  input  pafnf_pkg::mem_req_t req,
  output pafnf_pkg::entry_t rdata
);
  import pafnf_pkg::*;

  entry_t mem [MaxParts];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

endmodule

[rtl/partition_allocator_first_next_fit_core.sv]
// channel  | signals                           | handshake
// ---------+-----------------------------------+------------------------------
// request  | func, job_id, request_size        | start && !busy
// result   | status, start_address             | done, one cycle, no stall
// config   | cfg_we, cfg_index, cfg_data       | cfg_we, written at once
// a request runs a duplicate/owner scan over the table; an alloc then runs a
// fit scan and an entry shift of up to MaxParts entries, a free a merge with
// its neighbours and a shift down. each scan or shift step is one read of the
// table memory (the address register, then its registered read). rst and a
// mem_units write start a clear of all MaxParts entries during which busy is
// high. results cannot stall.
module partition_allocator_first_next_fit_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic                           func,
  input  logic [15:0]                    job_id,
  input  logic [15:0]                    request_size,
  output logic                           done,
  output logic [2:0]                     status,
  output logic [15:0]                    start_address,
  input  logic                           cfg_we,
  input  logic                           cfg_index,
  input  logic [15:0]                    cfg_data
);
  import pafnf_pkg::*;

  typedef enum logic [9:0] {
    S_CLEAR = 10'b0000000001,
    S_IDLE  = 10'b0000000010,
    S_DUP   = 10'b0000000100,
    S_FIT   = 10'b0000001000,
    S_DECIDE= 10'b0000010000,
    S_SHUP  = 10'b0000100000,
    S_SHDN  = 10'b0001000000,
    S_FREE  = 10'b0010000000,
    S_FIX   = 10'b0100000000,
    S_DONE  = 10'b1000000000
  } state_t;

  state_t state;
  logic fit_policy;
  logic [AddrBits-1:0] mem_units;
  logic [CntBits-1:0] part_count;
  logic [IdxBits-1:0] rover;

  logic func_q;
  logic [15:0] id_q, size_q;
  logic [CntBits-1:0] k;
  logic [1:0] rd_pend;
  logic [IdxBits-1:0] rd_idx;
  logic [IdxBits-1:0] found;
  entry_t fe;
  logic [2:0] st_q;
  logic [15:0] addr_q;
  logic [2:0] fix_step;
  logic [CntBits-1:0] sh_i;
  entry_t prev_e, cur_e, next_e;
  logic have_prev, have_next;
  logic [1:0] merges;

  mem_req_t req;
  entry_t rdata;

  pafnf_table u_table (
    .clk(clk),
    .req(req),
    .rdata(rdata)
  );

  logic [CntBits:0] scan_sum;
  logic [IdxBits-1:0] scan_idx;
  always_comb begin
    scan_sum = (fit_policy ? {1'b0, CntBits'(rover)} : '0) + {1'b0, k};
    if (scan_sum >= {1'b0, part_count}) begin
      scan_sum = scan_sum - {1'b0, part_count};
    end
    scan_idx = scan_sum[IdxBits-1:0];
  end

  always_ff @(posedge clk) begin
    req.we <= 1'b0;
    done <= 1'b0;
    if (rst) begin
      state <= S_CLEAR;
      fit_policy <= 1'b0;
      mem_units <= MemReset;
      k <= '0;
      rd_pend <= '0;
      part_count <= CntBits'(1);
      rover <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_FIT_POLICY) begin
          fit_policy <= cfg_data[0];
        end else begin
          mem_units <= cfg_data;
          state <= S_CLEAR;
          k <= '0;
          part_count <= CntBits'(1);
          rover <= '0;
        end
      end
      unique case (state)
        S_CLEAR: begin
          if (!(cfg_we && cfg_index == REG_MEM_UNITS)) begin
            req.we <= 1'b1;
            req.waddr <= k[IdxBits-1:0];
            req.wdata <= '{start: '0, size: (k == '0) ? mem_units : '0,
                           owner: '0, used: 1'b0};
            if (k == CntBits'(MaxParts - 1)) begin
              state <= S_IDLE;
            end else begin
              k <= k + 1'b1;
            end
          end
        end
        S_IDLE: begin
          if (start) begin
            func_q <= func;
            id_q <= job_id;
            size_q <= request_size;
            k <= '0;
            rd_pend <= '0;
            if (job_id == '0 || (func == FUNC_ALLOC && request_size == '0)) begin
              st_q <= ST_BAD;
              state <= S_DONE;
            end else begin
              state <= S_DUP;
            end
            if (rover >= part_count[IdxBits-1:0] && CntBits'(rover) >= part_count) begin
              rover <= '0;
            end
          end
        end
        S_DUP: begin
          if (rd_pend == 2'd0) begin
            if (k == part_count) begin
              if (func_q == FUNC_FREE) begin
                st_q <= ST_NOTFOUND;
                state <= S_DONE;
              end else begin
                k <= '0;
                state <= S_FIT;
              end
            end else begin
              req.raddr <= k[IdxBits-1:0];
              rd_idx <= k[IdxBits-1:0];
              rd_pend <= 2'd2;
            end
          end else if (rd_pend == 2'd2) begin
            rd_pend <= 2'd1;
          end else begin
            rd_pend <= 2'd0;
            if (rdata.used && rdata.owner == id_q) begin
              if (func_q == FUNC_FREE) begin
                found <= rd_idx;
                cur_e <= rdata;
                addr_q <= rdata.start;
                fix_step <= '0;
                state <= S_FREE;
              end else begin
                st_q <= ST_EXISTS;
                state <= S_DONE;
              end
            end else begin
              k <= k + 1'b1;
            end
          end
        end
        S_FIT: begin
          if (rd_pend == 2'd0) begin
            if (k == part_count) begin
              st_q <= ST_NOSPACE;
              state <= S_DONE;
            end else begin
              req.raddr <= scan_idx;
              rd_idx <= scan_idx;
              rd_pend <= 2'd2;
            end
          end else if (rd_pend == 2'd2) begin
            rd_pend <= 2'd1;
          end else begin
            rd_pend <= 2'd0;
            if (!rdata.used && rdata.size >= size_q) begin
              found <= rd_idx;
              fe <= rdata;
              state <= S_DECIDE;
            end else begin
              k <= k + 1'b1;
            end
          end
        end
        S_DECIDE: begin
          addr_q <= fe.start;
          if (fe.size == size_q) begin
            req.we <= 1'b1;
            req.waddr <= found;
            req.wdata <= '{start: fe.start, size: fe.size, owner: id_q, used: 1'b1};
            if (fit_policy) begin
              rover <= found;
            end
            st_q <= ST_OK;
            state <= S_DONE;
          end else if (part_count >= CntBits'(MaxParts)) begin
            st_q <= ST_FULL;
            state <= S_DONE;
          end else begin
            sh_i <= part_count;
            rd_pend <= '0;
            state <= S_SHUP;
          end
        end
        S_SHUP: begin
          // move entries found+1..count-1 up by one, top first
          if (rd_pend == 2'd0) begin
            if (sh_i == CntBits'(found) + 1'b1) begin
              req.we <= 1'b1;
              req.waddr <= found + 1'b1;
              req.wdata <= '{start: fe.start + size_q, size: fe.size - size_q,
                             owner: '0, used: 1'b0};
              state <= S_FIX;
              fix_step <= '0;
            end else begin
              req.raddr <= sh_i[IdxBits-1:0] - 1'b1;
              rd_pend <= 2'd2;
            end
          end else if (rd_pend == 2'd2) begin
            rd_pend <= 2'd1;
          end else begin
            rd_pend <= 2'd0;
            req.we <= 1'b1;
            req.waddr <= sh_i[IdxBits-1:0];
            req.wdata <= rdata;
            sh_i <= sh_i - 1'b1;
          end
        end
        S_FIX: begin
          req.we <= 1'b1;
          req.waddr <= found;
          req.wdata <= '{start: fe.start, size: size_q, owner: id_q, used: 1'b1};
          part_count <= part_count + 1'b1;
          if (fit_policy) begin
            rover <= found + 1'b1;
          end else if (rover >= found) begin
            rover <= rover + 1'b1;
          end
          st_q <= ST_OK;
          state <= S_DONE;
        end
        S_FREE: begin
          // read neighbours, then write merged entry and, if any merged, start closing
          unique case (fix_step)
            3'd0: begin
              have_next <= (CntBits'(found) + 1'b1) < part_count;
              have_prev <= found != '0;
              req.raddr <= found + 1'b1;
              fix_step <= 3'd1;
            end
            3'd1: begin
              req.raddr <= found - 1'b1;
              fix_step <= 3'd2;
            end
            3'd2: begin
              next_e <= rdata;
              fix_step <= 3'd3;
            end
            3'd3: begin
              prev_e <= rdata;
              fix_step <= 3'd4;
            end
            default: begin
              logic mn, mp;
              logic [AddrBits-1:0] sz;
              logic [IdxBits-1:0] tgt;
              mn = have_next && !next_e.used;
              mp = have_prev && !prev_e.used;
              sz = cur_e.size + (mn ? next_e.size : '0) + (mp ? prev_e.size : '0);
              tgt = mp ? found - 1'b1 : found;
              req.we <= 1'b1;
              req.waddr <= tgt;
              req.wdata <= '{start: mp ? prev_e.start : cur_e.start, size: sz,
                             owner: '0, used: 1'b0};
              merges <= 2'(mn) + 2'(mp);
              sh_i <= CntBits'(tgt) + 1'b1;
              if (mp && CntBits'(rover) >= CntBits'(found)) begin
                rover <= (mn && CntBits'(rover) > CntBits'(found)) ?
                         ((rover == found + 1'b1) ? found - 1'b1 : rover - 2'd2) :
                         rover - 1'b1;
              end else if (mn && CntBits'(rover) > CntBits'(found)) begin
                rover <= rover - 1'b1;
              end
              rd_pend <= '0;
              if (!mn && !mp) begin
                st_q <= ST_OK;
                state <= S_DONE;
              end else begin
                state <= S_SHDN;
              end
            end
          endcase
        end
        S_SHDN: begin
          // pull entries down by merges, then zero the vacated tail
          if (rd_pend == 2'd0) begin
            if (sh_i + CntBits'(merges) >= part_count) begin
              if (sh_i >= part_count) begin
                part_count <= part_count - CntBits'(merges);
                st_q <= ST_OK;
                state <= S_DONE;
              end else begin
                req.we <= 1'b1;
                req.waddr <= sh_i[IdxBits-1:0];
                req.wdata <= '0;
                sh_i <= sh_i + 1'b1;
              end
            end else begin
              req.raddr <= sh_i[IdxBits-1:0] + IdxBits'(merges);
              rd_pend <= 2'd2;
            end
          end else if (rd_pend == 2'd2) begin
            rd_pend <= 2'd1;
          end else begin
            rd_pend <= 2'd0;
            req.we <= 1'b1;
            req.waddr <= sh_i[IdxBits-1:0];
            req.wdata <= rdata;
            sh_i <= sh_i + 1'b1;
          end
        end
        S_DONE: begin
          done <= 1'b1;
          status <= st_q;
          start_address <= (st_q == ST_OK) ? addr_q : '0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign busy = (state != S_IDLE);

endmodule
